### src/wes_pkg.sv
// shared types, constants and helpers for the wheel encoder speed conditioner
package wes_pkg;

	localparam int COUNT_W     = 16;
	localparam int LIMIT_W     = 15;
	localparam int MPC_W       = 24;
	localparam int TOTAL_W     = 32;
	localparam int DIST_W      = 48;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 24;

	localparam int DEF_WINDOW_DEPTH = 8;

	localparam logic [LIMIT_W-1:0] MAX_SPEED_RST    = 15'd1000;
	localparam logic [LIMIT_W-1:0] DEAD_ZONE_RST    = 15'd2;
	localparam logic [MPC_W-1:0]   MM_PER_COUNT_RST = 24'd12868;

	// saturation magnitudes of the distance in Q32.16
	localparam logic [DIST_W-1:0] DIST_POS_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [DIST_W-1:0] DIST_NEG_MAG = 48'h8000_0000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_SPEED    = 2'd0,
		CFG_DEAD_ZONE    = 2'd1,
		CFG_MM_PER_COUNT = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic                      command;
		logic signed [COUNT_W-1:0] left_count;
		logic signed [COUNT_W-1:0] right_count;
	} in_t;

	typedef struct packed {
		logic signed [COUNT_W-1:0] left_speed;
		logic signed [COUNT_W-1:0] right_speed;
		logic signed [COUNT_W-1:0] left_filtered;
		logic signed [COUNT_W-1:0] right_filtered;
		logic signed [DIST_W-1:0]  left_distance;
		logic signed [DIST_W-1:0]  right_distance;
	} out_t;

	// one window entry for both wheels
	typedef struct packed {
		logic signed [COUNT_W-1:0] left;
		logic signed [COUNT_W-1:0] right;
	} pair_t;

	// load enables of the back end stages
	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	// running window sum width: room for depth times the largest speed
	function automatic int sum_width(input int depth);
		return COUNT_W + 1 + $clog2(depth);
	endfunction

	function automatic logic signed [TOTAL_W-1:0] sat_add_total(
		input logic signed [TOTAL_W-1:0] total,
		input logic signed [COUNT_W-1:0] add
	);
		logic signed [TOTAL_W:0] s;
		s = (TOTAL_W+1)'(total) + (TOTAL_W+1)'(add);
		if (s[TOTAL_W] != s[TOTAL_W-1]) begin
			return s[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}} : {1'b0, {(TOTAL_W-1){1'b1}}};
		end
		return s[TOTAL_W-1:0];
	endfunction

endpackage

### src/wes_cond.sv
// clamp and dead zone of one wheel count
module wes_cond (
	input  logic signed [wes_pkg::COUNT_W:0]   count,
	input  logic        [wes_pkg::LIMIT_W-1:0] max_speed,
	input  logic        [wes_pkg::LIMIT_W-1:0] dead_zone,
	output logic signed [wes_pkg::COUNT_W-1:0] speed
);
	import wes_pkg::*;

	logic signed [COUNT_W:0] lim;
	logic signed [COUNT_W:0] clp;
	logic signed [COUNT_W:0] mag;

	always_comb begin
		lim = $signed({2'b00, max_speed});
		priority if (count > lim) begin
			clp = lim;
		end else if (count < -lim) begin
			clp = -lim;
		end else begin
			clp = count;
		end
		mag = clp[COUNT_W] ? -clp : clp;
		if (mag < $signed({2'b00, dead_zone})) begin
			speed = '0;
		end else begin
			speed = clp[COUNT_W-1:0];
		end
	end

endmodule

### src/wes_cell.sv
// one window entry of both wheels, shifted on to its neighbor on each sample
module wes_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  wes_pkg::pair_t din,
	output wes_pkg::pair_t dout
);
	import wes_pkg::*;

	pair_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift) begin
			entry_q <= din;
		end
	end

	assign dout = entry_q;

endmodule

### src/wes_post.sv
// per wheel back end: window mean by reciprocal multiply, distance scaling with saturation
module wes_post #(
	parameter int WINDOW_DEPTH = wes_pkg::DEF_WINDOW_DEPTH
) (
	input  logic                                  clk,
	input  wes_pkg::stage_en_t                    en,
	input  logic signed [wes_pkg::sum_width(WINDOW_DEPTH)-1:0] sum,
	input  logic signed [wes_pkg::TOTAL_W-1:0]    total,
	input  logic        [wes_pkg::MPC_W-1:0]      mm_per_count,
	output logic signed [wes_pkg::COUNT_W-1:0]    filtered,
	output logic signed [wes_pkg::DIST_W-1:0]     distance
);
	import wes_pkg::*;

	localparam int SW = sum_width(WINDOW_DEPTH);
	// shift large enough that floor(x * RECIP / 2^K) is exact for every |sum|
	localparam int K  = SW + $clog2(WINDOW_DEPTH) + 1;
	localparam logic [K:0] RECIP = (K+1)'(((64'd1 << K) / WINDOW_DEPTH) + 64'd1);
	localparam int PW = TOTAL_W + MPC_W;

	logic                  fneg_s3, fneg_s4;
	logic [SW-1:0]         fmag_s3;
	logic [SW+K:0]         fprod_s4;
	logic                  dneg_s3, dneg_s4;
	logic [TOTAL_W-1:0]    dmag_s3;
	logic [PW-1:0]         dprod_s4;
	logic signed [COUNT_W-1:0] filt_s5;
	logic signed [DIST_W-1:0]  dist_s5;

	logic [COUNT_W-1:0] quot;
	logic [DIST_W-1:0]  dsat;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			fneg_s3 <= sum[SW-1];
			fmag_s3 <= sum[SW-1] ? SW'(-sum) : SW'(sum);
			dneg_s3 <= total[TOTAL_W-1];
			dmag_s3 <= total[TOTAL_W-1] ? TOTAL_W'(-total) : TOTAL_W'(total);
		end
		if (en.s4) begin
			fneg_s4  <= fneg_s3;
			fprod_s4 <= (SW+K+1)'(fmag_s3) * (SW+K+1)'(RECIP);
			dneg_s4  <= dneg_s3;
			dprod_s4 <= PW'(dmag_s3) * PW'(mm_per_count);
		end
		if (en.s5) begin
			filt_s5 <= fneg_s4 ? $signed(-quot) : $signed(quot);
			dist_s5 <= dneg_s4 ? $signed(-dsat) : $signed(dsat);
		end
	end

	always_comb begin
		quot = fprod_s4[K +: COUNT_W];
		if (dneg_s4) begin
			dsat = (dprod_s4 > PW'(DIST_NEG_MAG)) ? DIST_NEG_MAG : dprod_s4[DIST_W-1:0];
		end else begin
			dsat = (dprod_s4 > PW'(DIST_POS_MAX)) ? DIST_POS_MAX : dprod_s4[DIST_W-1:0];
		end
	end

	assign filtered = filt_s5;
	assign distance = dist_s5;

endmodule

### src/wheel_encoder_speed_conditioner.sv
// top level of the two wheel encoder speed conditioner
//
// input channel (in_valid/in_ready/in_data): one transfer per control tick; command 0 carries
// raw left and right counts, command 1 clears the distance totals and leaves the windows alone.
// the left count is inverted, both counts are clamped to +/-max_speed and dead-zoned.
// output channel (out_valid/out_ready/out_data): exactly one result per input transfer, in order,
// with the conditioned speeds, the window means and the Q32.16 millimetre distances.
// config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write only while idle.
// a result passes through the registers of stages one to five before it reaches out_data; throughput
// is one item per cycle while out_ready stays high, set by the five stage pipeline where the window
// sums and totals update in stage two.
// the window is a row of WINDOW_DEPTH cells that shift on each sample tick; the oldest entry
// falls out of the last cell and is subtracted from the running sum.
// reset clears the window, the sums, the totals and all valid flags, and loads the
// registers with max_speed 1000, dead_zone 2 and mm_per_count 12868.
// when the receiver stalls, the output holds and each stage keeps taking items until it is
// full, so up to five items can be in flight before in_ready drops.
module wheel_encoder_speed_conditioner #(
	parameter int WINDOW_DEPTH = wes_pkg::DEF_WINDOW_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  wes_pkg::in_t                      in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output wes_pkg::out_t                     out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wes_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wes_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import wes_pkg::*;

	localparam int SW = sum_width(WINDOW_DEPTH);

	logic [LIMIT_W-1:0] max_q;
	logic [LIMIT_W-1:0] dz_q;
	logic [MPC_W-1:0]   mpc_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;
	logic adv2;
	stage_en_t post_en;

	logic signed [COUNT_W:0]   lraw, rraw;
	logic signed [COUNT_W-1:0] lcond, rcond;

	logic  cmd_s1;
	pair_t spd_s1, spd_s2, spd_s3, spd_s4, spd_s5;

	pair_t cell_d [WINDOW_DEPTH+1];
	logic  shift;

	logic signed [SW-1:0]      sum_l_q, sum_r_q, sum_l_nxt, sum_r_nxt, sum_l_s2, sum_r_s2;
	logic signed [TOTAL_W-1:0] tot_l_q, tot_r_q, tot_l_nxt, tot_r_nxt, tot_l_s2, tot_r_s2;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_SPEED_RST;
			dz_q  <= DEAD_ZONE_RST;
			mpc_q <= MM_PER_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MAX_SPEED:    max_q <= cfg_data[LIMIT_W-1:0];
				CFG_DEAD_ZONE:    dz_q  <= cfg_data[LIMIT_W-1:0];
				CFG_MM_PER_COUNT: mpc_q <= cfg_data[MPC_W-1:0];
				default: ;
			endcase
		end
	end

	// each stage loads when it is empty or its successor moves on
	assign en5 = !v_s5 || out_ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;
	assign adv2 = v_s1 && en2;
	assign post_en = '{s3: en3, s4: en4, s5: en5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// stage one: inversion at 17 bits so the most negative count survives, then conditioning
	assign lraw = -$signed({in_data.left_count[COUNT_W-1], in_data.left_count});
	assign rraw = $signed({in_data.right_count[COUNT_W-1], in_data.right_count});

	wes_cond u_cond_l (.count(lraw), .max_speed(max_q), .dead_zone(dz_q), .speed(lcond));
	wes_cond u_cond_r (.count(rraw), .max_speed(max_q), .dead_zone(dz_q), .speed(rcond));

	always_ff @(posedge clk) begin
		if (en1) begin
			cmd_s1 <= in_data.command;
			spd_s1 <= in_data.command ? '0 : pair_t'{left: lcond, right: rcond};
		end
	end

	// window cells
	assign shift = adv2 && !cmd_s1;
	assign cell_d[0] = spd_s1;

	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		wes_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (shift),
			.din   (cell_d[i]),
			.dout  (cell_d[i+1])
		);
	end

	// stage two: running sums and saturating totals
	always_comb begin
		if (cmd_s1) begin
			sum_l_nxt = sum_l_q;
			sum_r_nxt = sum_r_q;
			tot_l_nxt = '0;
			tot_r_nxt = '0;
		end else begin
			sum_l_nxt = sum_l_q + SW'(spd_s1.left) - SW'(cell_d[WINDOW_DEPTH].left);
			sum_r_nxt = sum_r_q + SW'(spd_s1.right) - SW'(cell_d[WINDOW_DEPTH].right);
			tot_l_nxt = sat_add_total(tot_l_q, spd_s1.left);
			tot_r_nxt = sat_add_total(tot_r_q, spd_s1.right);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_l_q <= '0;
			sum_r_q <= '0;
			tot_l_q <= '0;
			tot_r_q <= '0;
		end else if (adv2) begin
			sum_l_q <= sum_l_nxt;
			sum_r_q <= sum_r_nxt;
			tot_l_q <= tot_l_nxt;
			tot_r_q <= tot_r_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			spd_s2   <= spd_s1;
			sum_l_s2 <= sum_l_nxt;
			sum_r_s2 <= sum_r_nxt;
			tot_l_s2 <= tot_l_nxt;
			tot_r_s2 <= tot_r_nxt;
		end
		if (en3) spd_s3 <= spd_s2;
		if (en4) spd_s4 <= spd_s3;
		if (en5) spd_s5 <= spd_s4;
	end

	// stages three to five per wheel
	wes_post #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_post_l (
		.clk         (clk),
		.en          (post_en),
		.sum         (sum_l_s2),
		.total       (tot_l_s2),
		.mm_per_count(mpc_q),
		.filtered    (out_data.left_filtered),
		.distance    (out_data.left_distance)
	);

	wes_post #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_post_r (
		.clk         (clk),
		.en          (post_en),
		.sum         (sum_r_s2),
		.total       (tot_r_s2),
		.mm_per_count(mpc_q),
		.filtered    (out_data.right_filtered),
		.distance    (out_data.right_distance)
	);

	assign out_valid            = v_s5;
	assign out_data.left_speed  = spd_s5.left;
	assign out_data.right_speed = spd_s5.right;

	// conditioned speeds never leave the clamp range
	a_speed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (spd_s1.left <= $signed({2'b00, max_q})
			&& spd_s1.left >= -$signed({2'b00, max_q})
			&& spd_s1.right <= $signed({2'b00, max_q})
			&& spd_s1.right >= -$signed({2'b00, max_q})))
		else $error("conditioned speed outside clamp range");

	// a clear transfer zeroes the totals and leaves the window sums alone
	a_clear_totals: assert property (@(posedge clk) disable iff (!arst_n)
		(adv2 && cmd_s1) |=> (tot_l_q == '0 && tot_r_q == '0
			&& $stable(sum_l_q) && $stable(sum_r_q)))
		else $error("clear did not zero totals or disturbed window sums");

	// the input side only stalls when the pipeline is full behind a held result
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready && v_s1 && v_s2 && v_s3 && v_s4))
		else $error("input stalled with room in the pipeline");

endmodule
